// ===== rtl/core/sph_pkg.sv =====
// ----------------------------------------------------------------------------
// sph_pkg: shared types and constants for the SPH density block
// Transaction payloads, op and status codes, table sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sph_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  localparam logic [47:0] DENSITY_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef enum logic {
    CFG_INV_H = 1'b0,
    CFG_NORM  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        mass;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] density;
    logic [10:0] particle_count;
  } rsp_t;

endpackage

// ===== rtl/core/sph_spline_density_sum.sv =====
// ----------------------------------------------------------------------------
// sph_spline_density_sum: SPH density with 2-D cubic spline kernel
// Particle table plus one shared multiplier and a bit-pair square root unit.
// ----------------------------------------------------------------------------
// Clear, load and undefined ops, and a query of an empty table: result
// registered in the cycle after acceptance.
// Query: stored particles are visited in turn, each passing through the
// 25-step sqrt and the single shared 34x34 multiplier (7 uses per particle when q < 2).
// One transaction at a time; req_ready is low while a query is in progress.
// rst (synchronous) empties the table and restores register defaults.
`timescale 1ns / 1ps

module sph_spline_density_sum (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sph_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sph_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);
  import sph_pkg::*;

  localparam int MUL_W = 34;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DX, S_DY, S_D2, S_SQRT, S_Q, S_QW,
    S_K1, S_K2, S_K3, S_W, S_WM, S_ACC
  } state_t;

  state_t state;

  logic [23:0]      inv_h;
  logic [31:0]      norm;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;

  logic [63:0] mem [MAX_PARTICLES];
  logic [63:0] rd_data;

  logic signed [23:0] qx, qy;
  logic [24:0] dy_abs;
  logic [49:0] d2;
  logic [49:0] sq_n;
  logic [27:0] rem;
  logic [25:0] root;
  logic [4:0]  iter;
  logic [33:0] q;
  logic [16:0] kb;
  logic        inner;
  logic [32:0] q2;
  logic [32:0] f;
  logic [31:0] w;
  logic [47:0] dens;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;

  logic signed [24:0] dx, dy;
  logic [24:0] dx_abs, dy_abs_c;
  logic [29:0] rem_sh, trial;
  logic [63:0] four_f_in;
  logic [47:0] term;
  logic [47:0] headroom;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE) && !rsp_valid;

  always_comb begin
    dx = 25'(qx) - 25'(signed'(rd_data[63:40]));
    dy = 25'(qy) - 25'(signed'(rd_data[39:16]));
    dx_abs = dx[24] ? 25'(-dx) : 25'(dx);
    dy_abs_c = dy[24] ? 25'(-dy) : 25'(dy);
    rem_sh = {rem, sq_n[49:48]};
    trial = {2'b00, root, 2'b01};
    q = prod[49:16];
    four_f_in = (64'd4 << 48) + (prod[63:0] << 1) + prod[63:0]
              - (64'(q2) << 18) - (64'(q2) << 17);
    term = prod[47:0];
    headroom = DENSITY_MAX - dens;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DX: begin
        mul_a = MUL_W'(dx_abs);
        mul_b = MUL_W'(dx_abs);
      end
      S_DY: begin
        mul_a = MUL_W'(dy_abs);
        mul_b = MUL_W'(dy_abs);
      end
      S_Q: begin
        mul_a = MUL_W'(root);
        mul_b = MUL_W'(inv_h);
      end
      S_K1: begin
        mul_a = MUL_W'(kb);
        mul_b = MUL_W'(kb);
      end
      S_K2: begin
        mul_a = MUL_W'(prod[32:0]);
        mul_b = MUL_W'(kb);
      end
      S_W: begin
        mul_a = MUL_W'(norm);
        mul_b = MUL_W'(f);
      end
      S_WM: begin
        mul_a = MUL_W'(prod[63:32]);
        mul_b = MUL_W'(rd_data[15:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // particle table: x, y, mass packed per entry
  always_ff @(posedge clk) begin
    if (req_valid && req_ready && req.op == OP_LOAD && count < CNT_W'(MAX_PARTICLES))
      mem[count[IDX_W-1:0]] <= {req.pos_x, req.pos_y, req.mass};
    rd_data <= mem[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inv_h     <= 24'd655360;
      norm      <= 32'd2980116;
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_INV_H: inv_h <= cfg_data[23:0];
          CFG_NORM:  norm  <= cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready)
        rsp_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            rsp.density <= '0;
            case (req.op)
              OP_CLEAR: begin
                count <= '0;
                rsp.status <= ST_OK;
                rsp.particle_count <= '0;
                rsp_valid <= 1'b1;
              end
              OP_LOAD: begin
                if (count < CNT_W'(MAX_PARTICLES)) begin
                  count <= count + 1'b1;
                  rsp.status <= ST_OK;
                  rsp.particle_count <= 11'(count + 1'b1);
                end else begin
                  rsp.status <= ST_FULL;
                  rsp.particle_count <= 11'(count);
                end
                rsp_valid <= 1'b1;
              end
              OP_QUERY: begin
                rsp.status <= ST_OK;
                rsp.particle_count <= 11'(count);
                qx   <= req.pos_x;
                qy   <= req.pos_y;
                dens <= '0;
                idx  <= '0;
                if (count == '0) rsp_valid <= 1'b1;
                else state <= S_RD;
              end
              default: begin
                rsp.status <= ST_OK;
                rsp.particle_count <= 11'(count);
                rsp_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RD: state <= S_DX;
        S_DX: begin
          dy_abs <= dy_abs_c;
          state  <= S_DY;
        end
        S_DY: begin
          d2    <= prod[49:0];
          state <= S_D2;
        end
        S_D2: begin
          sq_n  <= d2 + prod[49:0];
          rem   <= '0;
          root  <= '0;
          iter  <= 5'd24;
          state <= S_SQRT;
        end
        S_SQRT: begin
          // one result bit per step, two radicand bits consumed
          if (rem_sh >= trial) begin
            rem  <= 28'(rem_sh - trial);
            root <= {root[24:0], 1'b1};
          end else begin
            rem  <= rem_sh[27:0];
            root <= {root[24:0], 1'b0};
          end
          sq_n <= {sq_n[47:0], 2'b00};
          iter <= iter - 1'b1;
          if (iter == '0) state <= S_Q;
        end
        S_Q: state <= S_QW;
        S_QW: begin
          // branch on q straight from the product; kb is ready for S_K1
          if (q <= 34'd65536) begin
            inner <= 1'b1;
            kb    <= q[16:0];
            state <= S_K1;
          end else if (q < 34'd131072) begin
            inner <= 1'b0;
            kb    <= 17'(18'd131072 - {1'b0, q[16:0]});
            state <= S_K1;
          end else begin
            f     <= '0;
            state <= S_W;
          end
        end
        S_K1: state <= S_K2;
        S_K2: begin
          q2    <= prod[32:0];
          state <= S_K3;
        end
        S_K3: begin
          if (inner) f <= four_f_in[50:18];
          else       f <= prod[50:18];
          state <= S_W;
        end
        S_W:  state <= S_WM;
        S_WM: state <= S_ACC;
        S_ACC: begin
          if (term > headroom) begin
            rsp.status  <= ST_SAT;
            rsp.density <= DENSITY_MAX;
            rsp_valid   <= 1'b1;
            state       <= S_IDLE;
          end else if (idx + 1'b1 == count) begin
            rsp.density <= dens + term;
            rsp_valid   <= 1'b1;
            state       <= S_IDLE;
          end else begin
            dens  <= dens + term;
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
